[rtl/thsu_pkg.sv]
// Shared types and constants for the timestamp hit stream unpacker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package thsu_pkg;

    localparam int NUM_CHANNELS_DEF = 128;
    localparam int EPOCH_BITS_DEF   = 16;

    localparam int STAMP_BITS = 24;
    localparam int CHAN_W     = 7;
    localparam int TIME_W     = 40;
    localparam int COUNT_W    = 16;
    localparam int TOTAL_W    = 32;
    localparam int QDEPTH     = 4;

    localparam logic [7:0] TOP_WRAP   = 8'hFF;
    localparam logic [7:0] TOP_SCALER = 8'hFE;
    localparam logic [7:0] ARM_CODE   = 8'h80;

    typedef enum logic [1:0] {
        KIND_WRAP    = 2'd0,
        KIND_SCALER  = 2'd1,
        KIND_HIT     = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    // decoded word as it sits in the queue
    typedef struct packed {
        t_kind                  kind;
        logic [CHAN_W-1:0]      channel;
        logic                   in_range;
        logic                   edge_bit;
        logic [STAMP_BITS-1:0]  stamp;
        logic [COUNT_W-1:0]     low16;
        logic                   arm;
    } t_item;

    typedef struct packed {
        t_kind                  kind;
        logic [CHAN_W-1:0]      channel;
        logic                   edge_res;
        logic                   first_hit;
        logic [TIME_W-1:0]      time_ticks;
        logic [TIME_W-1:0]      delta_ticks;
        logic                   missing_edge;
        logic                   missing_wrap;
        logic                   unexpected_wrap;
        logic                   counter_jump;
        logic [TOTAL_W-1:0]     good_wraps;
        logic [COUNT_W-1:0]     scaler_words;
    } t_result;

endpackage

[rtl/timestamp_hit_stream_unpacker_top.sv]
// Top level of the timestamp hit stream unpacker: front decoder, item queue
// and back end. Depends on thsu_pkg, thsu_front, thsu_fifo and thsu_back.
`timescale 1ns / 1ps

// One 32-bit stream word is taken per clock while o_in_stall is low, and
// gives exactly one result, in order, via the queue, stage register r_s1
// and output register. With the output free the sustained rate is one word
// per cycle, set by the per-channel stamp/epoch memory: read as a word
// leaves the queue, written as it leaves r_s1, with the last write bypassed
// to a following hit on the same channel. A four-entry queue between decoder
// and back end lets the input keep flowing while a result waits on a stalled
// output. Per-channel seen/expect/edge bits are flip-flops cleared by reset,
// so no clearing pass is needed.
module timestamp_hit_stream_unpacker_top import thsu_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int EPOCH_BITS   = EPOCH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [31:0]         i_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_kind,
    output logic [CHAN_W-1:0]   o_channel,
    output logic                o_edge_res,
    output logic                o_first_hit,
    output logic [TIME_W-1:0]   o_time_ticks,
    output logic [TIME_W-1:0]   o_delta_ticks,
    output logic                o_missing_edge,
    output logic                o_missing_wrap,
    output logic                o_unexpected_wrap,
    output logic                o_counter_jump,
    output logic [TOTAL_W-1:0]  o_good_wraps,
    output logic [COUNT_W-1:0]  o_scaler_words
);

    localparam int INFL_W = $clog2(QDEPTH + 3);

    t_item   front_item;
    t_item   q_item;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    push;
    t_result res;

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    thsu_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_word (i_word),
        .o_item (front_item)
    );

    thsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    thsu_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .EPOCH_BITS   (EPOCH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_res_valid  (o_out_valid),
        .o_res        (res),
        .i_res_stall  (i_out_stall)
    );

    assign o_kind            = res.kind;
    assign o_channel         = res.channel;
    assign o_edge_res        = res.edge_res;
    assign o_first_hit       = res.first_hit;
    assign o_time_ticks      = res.time_ticks;
    assign o_delta_ticks     = res.delta_ticks;
    assign o_missing_edge    = res.missing_edge;
    assign o_missing_wrap    = res.missing_wrap;
    assign o_unexpected_wrap = res.unexpected_wrap;
    assign o_counter_jump    = res.counter_jump;
    assign o_good_wraps      = res.good_wraps;
    assign o_scaler_words    = res.scaler_words;

    // requests in flight: accepted words whose results are not yet taken
    logic              in_acc, out_acc;
    logic [INFL_W-1:0] r_inflight, n_inflight;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_comb begin
        case ({in_acc, out_acc})
            2'b10:   n_inflight = r_inflight + INFL_W'(1);
            2'b01:   n_inflight = r_inflight - INFL_W'(1);
            default: n_inflight = r_inflight;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= INFL_W'(QDEPTH + 2))
        else $error("more requests in flight than queue and stages hold");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != '0)
        else $error("result offered with no request outstanding");

endmodule

[rtl/thsu_front.sv]
// Front end: classifies a raw stream word into a queue item.
// Depends on thsu_pkg.
`timescale 1ns / 1ps

module thsu_front import thsu_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic [31:0] i_word,
    output t_item       o_item
);

    logic [7:0] top_byte;

    assign top_byte = i_word[31:24];

    always_comb begin
        o_item          = '0;
        o_item.channel  = i_word[30:24];
        o_item.stamp    = {i_word[23:1], 1'b0};
        o_item.edge_bit = i_word[0];
        o_item.low16    = i_word[15:0];
        o_item.arm      = (i_word[23:16] == ARM_CODE);
        o_item.in_range = (32'(i_word[30:24]) < NUM_CHANNELS);
        if (top_byte == TOP_WRAP) begin
            o_item.kind = KIND_WRAP;
        end else if (top_byte == TOP_SCALER) begin
            o_item.kind = KIND_SCALER;
        end else if (i_word[31]) begin
            o_item.kind = KIND_HIT;
        end else begin
            o_item.kind = KIND_UNKNOWN;
        end
    end

endmodule

[rtl/thsu_fifo.sv]
// Short queue of decoded items between front and back end.
// Depends on thsu_pkg.
`timescale 1ns / 1ps

module thsu_fifo import thsu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_item              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/thsu_back.sv]
// Back end: per-channel read-modify-write of edge, stamp and epoch state,
// wrap counter checking and the output register. Depends on thsu_pkg.
`timescale 1ns / 1ps

module thsu_back import thsu_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int EPOCH_BITS   = EPOCH_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_stall
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // stamp and epoch live in memories; r_seen doubles as their valid bits
    logic [STAMP_BITS-1:0]  mem_stamp [NUM_CHANNELS];
    logic [EPOCH_BITS-1:0]  mem_epoch [NUM_CHANNELS];

    logic                   r_s1_valid;
    t_item                  r_s1;
    logic [STAMP_BITS-1:0]  r_rd_stamp;
    logic [EPOCH_BITS-1:0]  r_rd_epoch;
    logic                   r_byp;
    logic [STAMP_BITS-1:0]  r_byp_stamp;
    logic [EPOCH_BITS-1:0]  r_byp_epoch;

    logic [NUM_CHANNELS-1:0] r_seen,   n_seen;
    logic [NUM_CHANNELS-1:0] r_expect, n_expect;
    logic [NUM_CHANNELS-1:0] r_edge,   n_edge;
    logic [COUNT_W-1:0]      r_prev_wc, n_prev_wc;
    logic [TOTAL_W-1:0]      r_wrap_total, n_wrap_total;

    logic                   r_out_valid;
    t_result                r_out;
    t_result                res;

    logic                   fire;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       pop_idx;
    logic                   wr_en;
    logic [STAMP_BITS-1:0]  wr_stamp;
    logic [EPOCH_BITS-1:0]  wr_epoch;
    logic [STAMP_BITS-1:0]  old_stamp;
    logic [EPOCH_BITS-1:0]  old_epoch;
    logic [EPOCH_BITS-1:0]  new_epoch;
    logic [63:0]            old_ext, new_ext;

    assign fire        = r_s1_valid && (!r_out_valid || !i_res_stall);
    assign o_pop       = i_item_valid && (!r_s1_valid || fire);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign idx     = r_s1.in_range ? r_s1.channel[IDX_W-1:0] : '0;
    assign pop_idx = i_item.in_range ? i_item.channel[IDX_W-1:0] : '0;

    // last write bypasses the memory for a back-to-back hit on one channel
    assign old_stamp = r_byp ? r_byp_stamp : r_rd_stamp;
    assign old_epoch = r_byp ? r_byp_epoch : r_rd_epoch;
    assign old_ext   = 64'({old_epoch, old_stamp});
    assign new_ext   = 64'({new_epoch, r_s1.stamp});

    always_comb begin
        res          = '0;
        res.kind     = r_s1.kind;
        n_seen       = r_seen;
        n_expect     = r_expect;
        n_edge       = r_edge;
        n_prev_wc    = r_prev_wc;
        n_wrap_total = r_wrap_total;
        wr_en        = 1'b0;
        wr_stamp     = r_s1.stamp;
        wr_epoch     = '0;
        new_epoch    = old_epoch;
        case (r_s1.kind)
            KIND_WRAP: begin
                // zero stored counter means no previous marker; no mod-2^16 wrap
                if (r_prev_wc != '0) begin
                    if ({1'b0, r_s1.low16} != ({1'b0, r_prev_wc} + 17'd1)) begin
                        res.counter_jump = 1'b1;
                    end else begin
                        n_wrap_total = r_wrap_total + TOTAL_W'(1);
                    end
                end
                n_prev_wc = r_s1.low16;
                if (r_s1.arm) begin
                    n_expect = r_expect | r_seen;
                end
            end
            KIND_SCALER: begin
                res.scaler_words = r_s1.low16;
            end
            KIND_HIT: begin
                res.channel  = r_s1.channel;
                res.edge_res = r_s1.edge_bit;
                if (!r_s1.in_range) begin
                    res.first_hit  = 1'b1;
                    res.time_ticks = TIME_W'(r_s1.stamp);
                end else if (!r_seen[idx]) begin
                    n_seen[idx]    = 1'b1;
                    n_expect[idx]  = 1'b0;
                    n_edge[idx]    = r_s1.edge_bit;
                    wr_en          = 1'b1;
                    res.first_hit  = 1'b1;
                    res.time_ticks = TIME_W'(r_s1.stamp);
                end else begin
                    res.missing_edge = (r_s1.edge_bit == r_edge[idx]);
                    if (r_expect[idx]) begin
                        // equal stamp with an armed expectation still counts as a wrap
                        if (r_s1.stamp > old_stamp) begin
                            res.missing_wrap = 1'b1;
                        end else begin
                            new_epoch = old_epoch + EPOCH_BITS'(1);
                        end
                        n_expect[idx] = 1'b0;
                    end else if (r_s1.stamp < old_stamp) begin
                        res.unexpected_wrap = 1'b1;
                        new_epoch = old_epoch + EPOCH_BITS'(1);
                    end
                    res.time_ticks  = new_ext[TIME_W-1:0];
                    res.delta_ticks = new_ext[TIME_W-1:0] - old_ext[TIME_W-1:0];
                    n_edge[idx]     = r_s1.edge_bit;
                    wr_en           = 1'b1;
                    wr_epoch        = new_epoch;
                end
            end
            default: begin
            end
        endcase
        res.good_wraps = n_wrap_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_byp        <= 1'b0;
            r_seen       <= '0;
            r_expect     <= '0;
            r_edge       <= '0;
            r_prev_wc    <= '0;
            r_wrap_total <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
                r_byp      <= fire && wr_en && (idx == pop_idx);
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_seen       <= n_seen;
                r_expect     <= n_expect;
                r_edge       <= n_edge;
                r_prev_wc    <= n_prev_wc;
                r_wrap_total <= n_wrap_total;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1        <= i_item;
            r_rd_stamp  <= mem_stamp[pop_idx];
            r_rd_epoch  <= mem_epoch[pop_idx];
            r_byp_stamp <= wr_stamp;
            r_byp_epoch <= wr_epoch;
        end
        if (fire && wr_en) begin
            mem_stamp[idx] <= wr_stamp;
            mem_epoch[idx] <= wr_epoch;
        end
        if (fire) begin
            r_out <= res;
        end
    end

endmodule
